### hw/rtl/prp_pkg.sv
// Shared types, character codes and record builders for the pileup read-entry parser.
// No dependencies; used by pileup_read_entry_parser_core.
package prp_pkg;

  // Default upper limit on an indel count
  localparam longint unsigned MAX_INDEL_LEN_DEF = 64'd65535;

  // Result queue depth (a byte can give two records)
  localparam int RES_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_INS   = 2'd1,
    KIND_DEL   = 2'd2
  } prp_kind_t;

  // One result record
  typedef struct packed {
    prp_kind_t   kind;
    logic [7:0]  seq_byte;
    logic        read_start;
    logic [7:0]  map_quality;
    logic [7:0]  base_char;
    logic [15:0] insert_len;
    logic [15:0] delete_len;
    logic        read_end;
    logic        status;
    logic        final_result;
  } prp_result_t;

  // True for a legal base character
  function automatic logic is_base(input logic [7:0] b);
    logic hit;
    unique case (b) inside
      8'h2E, 8'h2C, 8'h41, 8'h43, 8'h47, 8'h54, 8'h4E,
      8'h61, 8'h63, 8'h67, 8'h74, 8'h6E, 8'h3C, 8'h3E,
      8'h2A, 8'h23: hit = 1'b1;
      default:      hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Entry summary record
  function automatic prp_result_t mk_summary(input logic start, input logic [7:0] qual,
                                             input logic [7:0] base, input logic [15:0] ins,
                                             input logic [15:0] del, input logic end_mark);
    prp_result_t r;
    r             = '0;
    r.kind        = KIND_ENTRY;
    r.read_start  = start;
    r.map_quality = qual;
    r.base_char   = base;
    r.insert_len  = ins;
    r.delete_len  = del;
    r.read_end    = end_mark;
    return r;
  endfunction

  // Malformed-entry record
  function automatic prp_result_t mk_malformed();
    prp_result_t r;
    r        = '0;
    r.kind   = KIND_ENTRY;
    r.status = 1'b1;
    return r;
  endfunction

  // Inserted or deleted sequence byte record
  function automatic prp_result_t mk_seq(input prp_kind_t kind, input logic [7:0] b);
    prp_result_t r;
    r          = '0;
    r.kind     = kind;
    r.seq_byte = b;
    return r;
  endfunction

endpackage

### hw/rtl/pileup_read_entry_parser_core.sv
// Pileup read-base column parser: input register, single-pass parse logic, result queue.
// Depends on prp_pkg (types, character codes, record builders).
//
//  channel | dir | tdata                         | tuser | tlast
//  in_     | in  | data_byte                     | -     | column_end
//  out_    | out | seq_byte .. status (see port) | kind  | final_result
//
// Cycles: one byte is taken per cycle while the queue has room; it is held in the input
// register and parsed there; its records go to the result queue, whose head drives out_.
// Two records of a byte leave one at a time, so the one-record-per-cycle out_ sets the rate.
// The parser advances only while the four-entry result queue has room for two records.
// Reset: synchronous, active low; returns the parser to idle and empties the queue.
// Stalls: out_tready low fills the queue, then holds the input register and drops in_tready.
module pileup_read_entry_parser_core #(
  parameter longint unsigned MAX_INDEL_LEN = prp_pkg::MAX_INDEL_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // column_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] seq_byte, [8] read_start, [16:9] map_quality,
                                  // [24:17] base_char, [40:25] insert_len,
                                  // [56:41] delete_len, [57] read_end, [58] status, rest 0
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // final_result
);

  localparam int CW    = $clog2(MAX_INDEL_LEN + 1);
  localparam int VW    = CW + 4;
  localparam int PTR_W = $clog2(prp_pkg::RES_DEPTH);
  localparam int CNT_W = $clog2(prp_pkg::RES_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_QUAL, PH_BASE, PH_AFTER_BASE, PH_INS_DIG, PH_INS_DATA,
    PH_AFTER_INS, PH_DEL_DIG, PH_DEL_DATA, PH_AFTER_DEL, PH_DROP
  } phase_t;

  // Input register
  logic       inp_v_r;
  logic [7:0] inp_byte_r;
  logic       inp_last_r;

  // Parse context
  phase_t      phase_r, phase_nxt;
  logic        start_r, start_nxt;
  logic [7:0]  qual_r, qual_nxt;
  logic [7:0]  base_r, base_nxt;
  logic [15:0] ins_r, ins_nxt;
  logic [15:0] del_r, del_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic        dseen_r, dseen_nxt;

  // Result queue
  prp_pkg::prp_result_t q_r [prp_pkg::RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  // Parse outputs
  prp_pkg::prp_result_t res [3];
  logic [1:0]  res_n;
  logic [1:0]  push_n;
  logic        do_after;
  logic        do_start;
  logic        is_digit;
  logic [VW-1:0] dig_val;
  logic        proc_fire;
  logic        pop;
  prp_pkg::prp_result_t head;

  // Handshake
  assign proc_fire = inp_v_r && (cnt_r <= CNT_W'(prp_pkg::RES_DEPTH - 2));
  assign in_tready = !inp_v_r || proc_fire;
  assign pop       = out_tvalid && out_tready;

  // Decimal accumulate
  assign is_digit = (inp_byte_r >= prp_pkg::CH_ZERO) && (inp_byte_r <= prp_pkg::CH_NINE);
  assign dig_val  = ({4'b0, rem_r} << 3) + ({4'b0, rem_r} << 1) + VW'(inp_byte_r[3:0]);

  // Parse one byte: at most two records are kept
  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    qual_nxt  = qual_r;
    base_nxt  = base_r;
    ins_nxt   = ins_r;
    del_nxt   = del_r;
    rem_nxt   = rem_r;
    dseen_nxt = dseen_r;
    res[0]    = '0;
    res[1]    = '0;
    res[2]    = '0;
    res_n     = 2'd0;
    do_start  = 1'b0;
    do_after  = (phase_r == PH_AFTER_BASE) || (phase_r == PH_AFTER_INS) ||
                (phase_r == PH_AFTER_DEL);

    // Phases other than the after-base/after-indel group
    unique case (phase_r) inside
      PH_IDLE: do_start = 1'b1;
      PH_QUAL: begin
        qual_nxt  = inp_byte_r;
        phase_nxt = PH_BASE;
      end
      PH_BASE: begin
        if (prp_pkg::is_base(inp_byte_r)) begin
          base_nxt  = inp_byte_r;
          phase_nxt = PH_AFTER_BASE;
        end else begin
          res[res_n] = prp_pkg::mk_malformed();
          res_n      = res_n + 2'd1;
          phase_nxt  = PH_DROP;
        end
      end
      PH_INS_DIG, PH_DEL_DIG: begin
        if (is_digit) begin
          dseen_nxt = 1'b1;
          if (dig_val > VW'(MAX_INDEL_LEN)) begin
            res[res_n] = prp_pkg::mk_malformed();
            res_n      = res_n + 2'd1;
            phase_nxt  = PH_DROP;
          end else begin
            rem_nxt = dig_val[CW-1:0];
          end
        end else if (!dseen_r) begin
          res[res_n] = prp_pkg::mk_malformed();
          res_n      = res_n + 2'd1;
          phase_nxt  = PH_DROP;
        end else begin
          if (phase_r == PH_INS_DIG) begin
            ins_nxt = 16'(rem_r);
          end else begin
            del_nxt = 16'(rem_r);
          end
          if (rem_r == '0) begin
            // Zero count: the byte belongs to what follows the indel
            phase_nxt = (phase_r == PH_INS_DIG) ? PH_AFTER_INS : PH_AFTER_DEL;
            do_after  = 1'b1;
          end else begin
            res[res_n] = prp_pkg::mk_seq((phase_r == PH_INS_DIG) ? prp_pkg::KIND_INS
                                                                 : prp_pkg::KIND_DEL,
                                         inp_byte_r);
            res_n      = res_n + 2'd1;
            rem_nxt    = rem_r - CW'(1);
            if (rem_r != CW'(1)) begin
              phase_nxt = (phase_r == PH_INS_DIG) ? PH_INS_DATA : PH_DEL_DATA;
            end else begin
              phase_nxt = (phase_r == PH_INS_DIG) ? PH_AFTER_INS : PH_AFTER_DEL;
            end
          end
        end
      end
      PH_INS_DATA, PH_DEL_DATA: begin
        res[res_n] = prp_pkg::mk_seq((phase_r == PH_INS_DATA) ? prp_pkg::KIND_INS
                                                              : prp_pkg::KIND_DEL,
                                     inp_byte_r);
        res_n      = res_n + 2'd1;
        rem_nxt    = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          phase_nxt = (phase_r == PH_INS_DATA) ? PH_AFTER_INS : PH_AFTER_DEL;
        end
      end
      default: ;
    endcase

    // After a base or an indel: extend, close with '$', or close and restart
    if (do_after) begin
      if ((inp_byte_r == prp_pkg::CH_PLUS) && (phase_nxt == PH_AFTER_BASE)) begin
        rem_nxt   = '0;
        dseen_nxt = 1'b0;
        phase_nxt = PH_INS_DIG;
      end else if ((inp_byte_r == prp_pkg::CH_MINUS) && (phase_nxt != PH_AFTER_DEL)) begin
        rem_nxt   = '0;
        dseen_nxt = 1'b0;
        phase_nxt = PH_DEL_DIG;
      end else if (inp_byte_r == prp_pkg::CH_DOLLAR) begin
        res[res_n] = prp_pkg::mk_summary(start_nxt, qual_nxt, base_nxt, ins_nxt, del_nxt,
                                         1'b1);
        res_n      = res_n + 2'd1;
        phase_nxt  = PH_IDLE;
      end else begin
        res[res_n] = prp_pkg::mk_summary(start_nxt, qual_nxt, base_nxt, ins_nxt, del_nxt,
                                         1'b0);
        res_n      = res_n + 2'd1;
        do_start   = 1'b1;
      end
    end

    // Start a new entry
    if (do_start) begin
      qual_nxt  = '0;
      ins_nxt   = '0;
      del_nxt   = '0;
      rem_nxt   = '0;
      dseen_nxt = 1'b0;
      if (inp_byte_r == prp_pkg::CH_CARET) begin
        start_nxt = 1'b1;
        phase_nxt = PH_QUAL;
      end else if (prp_pkg::is_base(inp_byte_r)) begin
        start_nxt = 1'b0;
        base_nxt  = inp_byte_r;
        phase_nxt = PH_AFTER_BASE;
      end else begin
        start_nxt  = 1'b0;
        res[res_n] = prp_pkg::mk_malformed();
        res_n      = res_n + 2'd1;
        phase_nxt  = PH_DROP;
      end
    end

    // Close the column
    if (inp_last_r) begin
      unique case (phase_nxt) inside
        PH_IDLE, PH_DROP: ;
        PH_AFTER_BASE, PH_AFTER_INS, PH_AFTER_DEL: begin
          res[res_n] = prp_pkg::mk_summary(start_nxt, qual_nxt, base_nxt, ins_nxt, del_nxt,
                                           1'b0);
          res_n      = res_n + 2'd1;
        end
        PH_INS_DIG, PH_DEL_DIG: begin
          if (dseen_nxt && (rem_nxt == '0)) begin
            res[res_n] = prp_pkg::mk_summary(start_nxt, qual_nxt, base_nxt, ins_nxt,
                                             del_nxt, 1'b0);
          end else begin
            res[res_n] = prp_pkg::mk_malformed();
          end
          res_n = res_n + 2'd1;
        end
        default: begin
          res[res_n] = prp_pkg::mk_malformed();
          res_n      = res_n + 2'd1;
        end
      endcase
      phase_nxt = PH_IDLE;
    end

    // Keep the first two records and mark the last one kept
    push_n = (res_n >= 2'd2) ? 2'd2 : res_n;
    if (push_n == 2'd1) begin
      res[0].final_result = 1'b1;
    end else if (push_n == 2'd2) begin
      res[1].final_result = 1'b1;
    end
  end

  // State, input register and result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_v_r  <= 1'b0;
      phase_r  <= PH_IDLE;
      start_r  <= 1'b0;
      qual_r   <= '0;
      base_r   <= '0;
      ins_r    <= '0;
      del_r    <= '0;
      rem_r    <= '0;
      dseen_r  <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      // Take the next request
      if (in_tready) begin
        inp_v_r <= in_tvalid;
      end
      // Advance the parser
      if (proc_fire) begin
        phase_r <= phase_nxt;
        start_r <= start_nxt;
        qual_r  <= qual_nxt;
        base_r  <= base_nxt;
        ins_r   <= ins_nxt;
        del_r   <= del_nxt;
        rem_r   <= rem_nxt;
        dseen_r <= dseen_nxt;
      end
      // Queue pointers
      if (proc_fire) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (proc_fire ? CNT_W'(push_n) : '0) - CNT_W'(pop);
    end
    // Payload holds
    if (in_tready && in_tvalid) begin
      inp_byte_r <= in_tdata;
      inp_last_r <= in_tlast;
    end
    if (proc_fire && (push_n != 2'd0)) begin
      q_r[wr_ptr_r] <= res[0];
    end
    if (proc_fire && (push_n == 2'd2)) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= res[1];
    end
  end

  // Output from the queue head
  assign head       = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.final_result;
  assign out_tdata  = {5'b0, head.status, head.read_end, head.delete_len, head.insert_len,
                       head.base_char, head.map_quality, head.read_start, head.seq_byte};

`ifndef NO_ASSERTIONS
  // Queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(prp_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  // Queue only grows when a byte is parsed
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    !proc_fire |=> cnt_r <= $past(cnt_r))
    else $error("queue grew without a parsed byte");

  // Column end returns the parser to idle
  a_col_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && inp_last_r |=> phase_r == PH_IDLE)
    else $error("parser not idle after column end");

  // Data phases always have bytes outstanding
  a_data_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_INS_DATA || phase_r == PH_DEL_DATA) |-> rem_r != '0)
    else $error("data phase with no bytes outstanding");
`endif

endmodule
